// File: hdl/sdi_pkg.sv
`default_nettype none
package sdi_pkg;

  localparam int REF_W     = 24;
  localparam int COMP_W    = 13;
  localparam int ILL_W     = 16;
  localparam int DIST_W    = 25;
  localparam int DIR_W     = 16;
  localparam int DIR_FB    = 14;
  localparam int DIR_QB    = DIR_FB + 1;
  localparam int SQ_SHIFT  = 2 * DIR_FB;
  localparam int IDX_W     = 3;
  localparam int CFG_DW    = 24;

  localparam logic [COMP_W-1:0] COMP_FULL = 13'd4096;
  localparam logic [DIR_W-1:0]  DIR_ONE   = 16'd16384;

  localparam logic [IDX_W-1:0] REG_STAR_PRESENT = 3'd0;
  localparam logic [IDX_W-1:0] REG_REF_DIST     = 3'd1;
  localparam logic [IDX_W-1:0] REG_COMPENSATION = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_ILLUM    = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_ILLUM    = 3'd4;

  typedef struct packed {
    logic              star_present;
    logic [REF_W-1:0]  reference_distance;
    logic [COMP_W-1:0] compensation;
    logic [ILL_W-1:0]  min_illumination;
    logic [ILL_W-1:0]  max_illumination;
  } cfg_t;

  typedef struct packed {
    logic nostar;
    logic zero;
  } flags_t;

endpackage
`default_nettype wire

// File: hdl/sdi_in_if.sv
`default_nettype none
interface sdi_in_if #(parameter int W = 24) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] planet_x;
  logic [W-1:0] planet_y;
  logic [W-1:0] planet_z;
  logic [W-1:0] star_x;
  logic [W-1:0] star_y;
  logic [W-1:0] star_z;
  modport source (output valid, planet_x, planet_y, planet_z, star_x, star_y, star_z,
                  input ready);
  modport sink (input valid, planet_x, planet_y, planet_z, star_x, star_y, star_z,
                output ready);
endinterface
`default_nettype wire

// File: hdl/sdi_out_if.sv
`default_nettype none
interface sdi_out_if ();
  logic                                valid;
  logic                                ready;
  logic        [sdi_pkg::DIST_W-1:0]   star_distance;
  logic signed [sdi_pkg::DIR_W-1:0]    dir_x;
  logic signed [sdi_pkg::DIR_W-1:0]    dir_y;
  logic signed [sdi_pkg::DIR_W-1:0]    dir_z;
  logic        [sdi_pkg::ILL_W-1:0]    illumination;
  modport source (output valid, star_distance, dir_x, dir_y, dir_z, illumination,
                  input ready);
  modport sink (input valid, star_distance, dir_x, dir_y, dir_z, illumination,
                output ready);
endinterface
`default_nettype wire

// File: hdl/sdi_cfg_if.sv
`default_nettype none
interface sdi_cfg_if ();
  logic                        valid;
  logic                        ready;
  logic [sdi_pkg::IDX_W-1:0]   index;
  logic [sdi_pkg::CFG_DW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/star_distance_illumination.sv
`default_nettype none
// channel   dir  handshake     word
// in_port   in   valid/ready   planet_x..z, star_x..z (POSITION_BITS each, signed)
// out_port  out  valid/ready   star_distance, dir_x..z (Q1.14), illumination (Q4.12)
// cfg_port  in   valid/ready   index, data (one register per write)
//
// One word in per cycle, one result word out per cycle, while out_port does not stall.
// Pipeline stages: 3 front, 19 reciprocal,
// POSITION_BITS + 17 square root (one bit per stage), 17 direction divide, 1 out.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// A stall on out_port freezes the whole pipeline; in_port.ready drops with it.
module star_distance_illumination #(
  parameter int POSITION_BITS = 24,
  parameter int FRACTION_BITS = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  sdi_in_if.sink           in_port,
  sdi_out_if.source        out_port,
  sdi_cfg_if.sink          cfg_port
);

  localparam int MW = POSITION_BITS + 1;
  localparam int SW = 2 * MW + 2;
  localparam int QW = (SW + sdi_pkg::SQ_SHIFT + 1) / 2;
  localparam int FLW = $bits(sdi_pkg::flags_t);
  localparam int ILW = sdi_pkg::ILL_W;
  localparam int DSW = sdi_pkg::DIST_W;
  localparam int RSB = SW + 3 * MW + 3 + FLW;
  localparam int QSB = 3 * MW + 3 + FLW + ILW;
  localparam int DSB = DSW + ILW + FLW;
  // 1.0 in Q4.12, saturated for wide fractions
  localparam logic [ILW-1:0] ONE_Q =
      (FRACTION_BITS >= 16) ? 16'hFFFF : 16'(32'd1 << FRACTION_BITS);

  sdi_pkg::cfg_t cfg_r;
  logic          en;
  logic          out_vld_r;

  // front
  logic                 f_vld;
  logic [2:0][MW-1:0]   f_m;
  logic [2:0]           f_neg;
  sdi_pkg::flags_t      f_fl;
  logic [SW-1:0]        f_s;

  // reciprocal
  logic                 r_vld;
  logic [ILW-1:0]       r_blend;
  logic [RSB-1:0]       r_sb;
  logic [SW-1:0]        r_s;
  logic [2:0][MW-1:0]   r_m;
  logic [2:0]           r_neg;
  sdi_pkg::flags_t      r_fl;

  // square root
  logic                 q_vld;
  logic [QW-1:0]        q_root;
  logic [QSB-1:0]       q_sb;
  logic [2:0][MW-1:0]   q_m;
  logic [2:0]           q_neg;
  sdi_pkg::flags_t      q_fl;
  logic [ILW-1:0]       q_blend;
  logic [QW:0]          dq_rnd;
  logic [DSW-1:0]       dist_c;

  // direction divide
  logic                               d_vld;
  logic [2:0][sdi_pkg::DIR_W-1:0]     d_dir;
  logic [DSB-1:0]                     d_sb;
  logic [DSW-1:0]                     d_dist;
  logic [ILW-1:0]                     d_blend;
  sdi_pkg::flags_t                    d_fl;

  // output stage
  logic [ILW-1:0]             ill_x, ill_c;
  logic [DSW-1:0]             dist_r;
  logic [sdi_pkg::DIR_W-1:0]  dx_r, dy_r, dz_r;
  logic [ILW-1:0]             ill_r;

  // config writes; unknown index is dropped
  assign cfg_port.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.star_present       <= 1'b0;
      cfg_r.reference_distance <= sdi_pkg::REF_W'(1);
      cfg_r.compensation       <= '0;
      cfg_r.min_illumination   <= '0;
      cfg_r.max_illumination   <= '1;
    end else if (cfg_port.valid) begin
      unique case (cfg_port.index)
        sdi_pkg::REG_STAR_PRESENT: cfg_r.star_present       <= cfg_port.data[0];
        sdi_pkg::REG_REF_DIST:     cfg_r.reference_distance <= cfg_port.data;
        sdi_pkg::REG_COMPENSATION:
          cfg_r.compensation <= cfg_port.data[sdi_pkg::COMP_W-1:0];
        sdi_pkg::REG_MIN_ILLUM:    cfg_r.min_illumination   <= cfg_port.data[ILW-1:0];
        sdi_pkg::REG_MAX_ILLUM:    cfg_r.max_illumination   <= cfg_port.data[ILW-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances when the output register is free or drained
  assign en            = !out_vld_r || out_port.ready;
  assign in_port.ready = en;

  sdi_front #(.PW(POSITION_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_vld       (in_port.valid),
    .px           (in_port.planet_x),
    .py           (in_port.planet_y),
    .pz           (in_port.planet_z),
    .sx           (in_port.star_x),
    .sy           (in_port.star_y),
    .sz           (in_port.star_z),
    .star_present (cfg_r.star_present),
    .out_vld      (f_vld),
    .m            (f_m),
    .neg          (f_neg),
    .flags        (f_fl),
    .s            (f_s)
  );

  sdi_recip #(.SW(SW), .FB(FRACTION_BITS), .SBW(RSB)) u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (f_vld),
    .s       (f_s),
    .cfg     (cfg_r),
    .in_sb   ({f_s, f_m, f_neg, f_fl}),
    .out_vld (r_vld),
    .blend   (r_blend),
    .out_sb  (r_sb)
  );

  assign {r_s, r_m, r_neg, r_fl} = r_sb;

  sdi_sqrt #(.SW(SW), .SBW(QSB)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (r_vld),
    .s       (r_s),
    .in_sb   ({r_m, r_neg, r_fl, r_blend}),
    .out_vld (q_vld),
    .root    (q_root),
    .out_sb  (q_sb)
  );

  assign {q_m, q_neg, q_fl, q_blend} = q_sb;

  // distance = (dq + half) >> 14, saturated
  assign dq_rnd = {1'b0, q_root} + ((QW+1)'(1) << (sdi_pkg::DIR_FB - 1));
  assign dist_c = ((dq_rnd >> (sdi_pkg::DIR_FB + DSW)) != '0) ? '1
                : DSW'(dq_rnd >> sdi_pkg::DIR_FB);

  sdi_dirdiv #(.MW(MW), .QW(QW), .SBW(DSB)) u_dirdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (q_vld),
    .m       (q_m),
    .neg     (q_neg),
    .dq      (q_root),
    .in_sb   ({dist_c, q_blend, q_fl}),
    .out_vld (d_vld),
    .dir     (d_dir),
    .out_sb  (d_sb)
  );

  assign {d_dist, d_blend, d_fl} = d_sb;

  // clamp as x<min ? min : (x<max ? x : max)
  assign ill_x = d_fl.nostar ? ONE_Q : d_blend;
  assign ill_c = (ill_x < cfg_r.min_illumination) ? cfg_r.min_illumination
               : ((ill_x < cfg_r.max_illumination) ? ill_x : cfg_r.max_illumination);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d_fl.nostar || d_fl.zero) begin
        // no star or coincident bodies: forward direction, zero distance
        dist_r <= '0;
        dx_r   <= sdi_pkg::DIR_ONE;
        dy_r   <= '0;
        dz_r   <= '0;
        ill_r  <= d_fl.nostar ? ill_c : cfg_r.max_illumination;
      end else begin
        dist_r <= d_dist;
        dx_r   <= d_dir[0];
        dy_r   <= d_dir[1];
        dz_r   <= d_dir[2];
        ill_r  <= ill_c;
      end
    end
  end

  assign out_port.valid         = out_vld_r;
  assign out_port.star_distance = dist_r;
  assign out_port.dir_x         = dx_r;
  assign out_port.dir_y         = dy_r;
  assign out_port.dir_z         = dz_r;
  assign out_port.illumination  = ill_r;

endmodule
`default_nettype wire

// File: hdl/sdi_front.sv
`default_nettype none
// difference, magnitude, squares, sum of squares: three stages
module sdi_front #(
  parameter int PW = 24,
  localparam int MW = PW + 1,
  localparam int SW = 2 * MW + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [PW-1:0]        px,
  input  logic [PW-1:0]        py,
  input  logic [PW-1:0]        pz,
  input  logic [PW-1:0]        sx,
  input  logic [PW-1:0]        sy,
  input  logic [PW-1:0]        sz,
  input  logic                 star_present,
  output logic                 out_vld,
  output logic [2:0][MW-1:0]   m,
  output logic [2:0]           neg,
  output sdi_pkg::flags_t      flags,
  output logic [SW-1:0]        s
);

  logic [MW-1:0] d_c [3];
  logic [2:0][MW-1:0] m_c;
  logic [2:0] neg_c;

  logic [2:0] vld_r;
  logic [2:0][MW-1:0] m1_r, m2_r, m3_r;
  logic [2:0] neg1_r, neg2_r, neg3_r;
  sdi_pkg::flags_t fl1_r, fl2_r, fl3_r;
  logic [2:0][2*MW-1:0] sq2_r;
  logic [SW-1:0] s3_r;

  always_comb begin
    d_c[0] = {sx[PW-1], sx} - {px[PW-1], px};
    d_c[1] = {sy[PW-1], sy} - {py[PW-1], py};
    d_c[2] = {sz[PW-1], sz} - {pz[PW-1], pz};
    for (int l = 0; l < 3; l++) begin
      neg_c[l] = d_c[l][MW-1];
      m_c[l]   = neg_c[l] ? (~d_c[l] + 1'b1) : d_c[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r         <= m_c;
      neg1_r       <= neg_c;
      fl1_r.nostar <= !star_present;
      fl1_r.zero   <= (m_c == '0);
      for (int l = 0; l < 3; l++) begin
        sq2_r[l] <= m1_r[l] * m1_r[l];
      end
      m2_r   <= m1_r;
      neg2_r <= neg1_r;
      fl2_r  <= fl1_r;
      s3_r   <= SW'(sq2_r[0]) + SW'(sq2_r[1]) + SW'(sq2_r[2]);
      m3_r   <= m2_r;
      neg3_r <= neg2_r;
      fl3_r  <= fl2_r;
    end
  end

  assign out_vld = vld_r[2];
  assign m       = m3_r;
  assign neg     = neg3_r;
  assign flags   = fl3_r;
  assign s       = s3_r;

endmodule
`default_nettype wire

// File: hdl/sdi_recip.sv
`default_nettype none
// raw = round(R^2 * 2^FB / S) by restoring division, one quotient bit per
// stage, then the blend toward 1.0
module sdi_recip #(
  parameter int SW  = 52,
  parameter int FB  = 12,
  parameter int SBW = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [SW-1:0]               s,
  input  sdi_pkg::cfg_t               cfg,
  input  logic [SBW-1:0]              in_sb,
  output logic                        out_vld,
  output logic [sdi_pkg::ILL_W-1:0]   blend,
  output logic [SBW-1:0]              out_sb
);

  localparam int RW = sdi_pkg::REF_W;
  localparam int NB = 2 * RW + FB;
  localparam int QB = sdi_pkg::ILL_W;
  localparam int NS = QB;
  localparam int DW = ((NB > SW + QB) ? NB : SW + QB) + 1;

  logic [RW-1:0]   ref_eff;
  logic [2*RW-1:0] ref_sq_r;
  logic [DW-1:0]   num_c;
  logic [DW-1:0]   s_top_c;

  logic [NS:0]     v_r;
  logic [NS:0]     sat_r;
  logic [SW-1:0]   s_r   [NS+1];
  logic [DW-1:0]   rem_r [NS+1];
  logic [QB-1:0]   t_r   [NS+1];
  logic [SBW-1:0]  sb_r  [NS+1];

  logic            rv_r, bv_r;
  logic [QB-1:0]   raw_r, blend_r;
  logic [SBW-1:0]  rsb_r, bsb_r;

  assign ref_eff = (cfg.reference_distance == '0) ? RW'(1) : cfg.reference_distance;
  assign num_c   = DW'({ref_sq_r, {FB{1'b0}}});
  assign s_top_c = DW'(s) << QB;

  // the reference must only change while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    ref_sq_r <= ref_eff * ref_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      rv_r <= 1'b0;
      bv_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[NS-1:0], in_vld};
      rv_r <= v_r[NS];
      bv_r <= rv_r;
    end
  end

  always_ff @(posedge clk) begin : div_pipe
    logic [DW-1:0]           sh;
    logic [SW:0]             r2;
    logic [31:0]             acc;
    logic [sdi_pkg::COMP_W-1:0] c;
    if (en) begin
      s_r[0]   <= s;
      rem_r[0] <= num_c;
      t_r[0]   <= '0;
      sat_r[0] <= (num_c >= s_top_c);
      sb_r[0]  <= in_sb;
      for (int k = 1; k <= NS; k++) begin
        sh       = DW'(s_r[k-1]) << (NS - k);
        s_r[k]   <= s_r[k-1];
        sat_r[k] <= sat_r[k-1];
        sb_r[k]  <= sb_r[k-1];
        if (rem_r[k-1] >= sh) begin
          rem_r[k] <= rem_r[k-1] - sh;
          t_r[k]   <= t_r[k-1] | (QB'(1) << (NS - k));
        end else begin
          rem_r[k] <= rem_r[k-1];
          t_r[k]   <= t_r[k-1];
        end
      end
      // round half up on the remainder, saturate
      r2 = {rem_r[NS][SW-1:0], 1'b0};
      if (sat_r[NS]) begin
        raw_r <= '1;
      end else if ((t_r[NS] != '1) && (r2 >= {1'b0, s_r[NS]})) begin
        raw_r <= t_r[NS] + 1'b1;
      end else begin
        raw_r <= t_r[NS];
      end
      rsb_r <= sb_r[NS];
      c   = (cfg.compensation > sdi_pkg::COMP_FULL) ? sdi_pkg::COMP_FULL : cfg.compensation;
      acc = 32'(raw_r) * 32'(sdi_pkg::COMP_FULL - c) + (32'(c) << FB) + 32'd2048;
      blend_r <= (acc[31:12] > 20'hFFFF) ? '1 : acc[27:12];
      bsb_r   <= rsb_r;
    end
  end

  assign out_vld = bv_r;
  assign blend   = blend_r;
  assign out_sb  = bsb_r;

endmodule
`default_nettype wire

// File: hdl/sdi_sqrt.sv
`default_nettype none
// floor(sqrt(S * 2^28)), one root bit per stage
module sdi_sqrt #(
  parameter int SW  = 52,
  parameter int SBW = 8,
  localparam int QW = (SW + sdi_pkg::SQ_SHIFT + 1) / 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [SW-1:0]   s,
  input  logic [SBW-1:0]  in_sb,
  output logic            out_vld,
  output logic [QW-1:0]   root,
  output logic [SBW-1:0]  out_sb
);

  logic [QW:0]    v_r;
  logic [SW-1:0]  s_r    [QW+1];
  logic [QW+1:0]  rem_r  [QW+1];
  logic [QW-1:0]  root_r [QW+1];
  logic [SBW-1:0] sb_r   [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin : sq_pipe
    logic [2*QW-1:0] xp;
    logic [QW+1:0]   r2;
    logic [QW+1:0]   trial;
    if (en) begin
      s_r[0]    <= s;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      sb_r[0]   <= in_sb;
      for (int k = 1; k <= QW; k++) begin
        xp    = (2*QW)'({s_r[k-1], {sdi_pkg::SQ_SHIFT{1'b0}}});
        r2    = {rem_r[k-1][QW-1:0], xp[2*(QW-k) +: 2]};
        trial = {root_r[k-1], 2'b01};
        s_r[k]  <= s_r[k-1];
        sb_r[k] <= sb_r[k-1];
        if (r2 >= trial) begin
          rem_r[k]  <= r2 - trial;
          root_r[k] <= {root_r[k-1][QW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= r2;
          root_r[k] <= {root_r[k-1][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld = v_r[QW];
  assign root    = root_r[QW];
  assign out_sb  = sb_r[QW];

endmodule
`default_nettype wire

// File: hdl/sdi_dirdiv.sv
`default_nettype none
// three lanes of round(m * 2^28 / dq), one quotient bit per stage
module sdi_dirdiv #(
  parameter int MW  = 25,
  parameter int QW  = 40,
  parameter int SBW = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [2:0][MW-1:0]                m,
  input  logic [2:0]                        neg,
  input  logic [QW-1:0]                     dq,
  input  logic [SBW-1:0]                    in_sb,
  output logic                              out_vld,
  output logic [2:0][sdi_pkg::DIR_W-1:0]    dir,
  output logic [SBW-1:0]                    out_sb
);

  localparam int QB  = sdi_pkg::DIR_QB;
  localparam int RWA = QW + QB + 1;
  localparam int RWB = MW + sdi_pkg::SQ_SHIFT + 1;
  localparam int RW  = (RWA > RWB) ? RWA : RWB;

  logic [QB:0]             v_r;
  logic [QW-1:0]           dq_r  [QB+1];
  logic [2:0]              neg_r [QB+1];
  logic [SBW-1:0]          sb_r  [QB+1];
  logic [RW-1:0]           rem_r [QB+1][3];
  logic [2:0][QB-1:0]      q_r   [QB+1];

  logic                            fv_r;
  logic [2:0][sdi_pkg::DIR_W-1:0]  dir_r;
  logic [SBW-1:0]                  fsb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      fv_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[QB-1:0], in_vld};
      fv_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin : dv_pipe
    logic [RW-1:0]              sh;
    logic [QB-1:0]              qc;
    logic [sdi_pkg::DIR_W-1:0]  qe;
    if (en) begin
      dq_r[0]  <= dq;
      neg_r[0] <= neg;
      sb_r[0]  <= in_sb;
      q_r[0]   <= '0;
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= (RW'(m[l]) << sdi_pkg::SQ_SHIFT) + RW'(dq >> 1);
      end
      for (int k = 1; k <= QB; k++) begin
        sh       = RW'(dq_r[k-1]) << (QB - k);
        dq_r[k]  <= dq_r[k-1];
        neg_r[k] <= neg_r[k-1];
        sb_r[k]  <= sb_r[k-1];
        for (int l = 0; l < 3; l++) begin
          if (rem_r[k-1][l] >= sh) begin
            rem_r[k][l] <= rem_r[k-1][l] - sh;
            q_r[k][l]   <= q_r[k-1][l] | (QB'(1) << (QB - k));
          end else begin
            rem_r[k][l] <= rem_r[k-1][l];
            q_r[k][l]   <= q_r[k-1][l];
          end
        end
      end
      // limit magnitude to 1.0, apply sign
      for (int l = 0; l < 3; l++) begin
        qc = (q_r[QB][l] > QB'(sdi_pkg::DIR_ONE)) ? QB'(sdi_pkg::DIR_ONE) : q_r[QB][l];
        qe = {1'b0, qc};
        dir_r[l] <= neg_r[QB][l] ? (~qe + 1'b1) : qe;
      end
      fsb_r <= sb_r[QB];
    end
  end

  assign out_vld = fv_r;
  assign dir     = dir_r;
  assign out_sb  = fsb_r;

endmodule
`default_nettype wire

// File: hdl/sdi_checker.sv
`default_nettype none
module sdi_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sdi_pkg::DIST_W-1:0]    star_dist,
  input logic [sdi_pkg::DIR_W-1:0]     dx,
  input logic [sdi_pkg::DIR_W-1:0]     dy,
  input logic [sdi_pkg::DIR_W-1:0]     dz
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped under stall");

  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("valid result right after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (star_dist == '0) |-> (dx == sdi_pkg::DIR_ONE) && (dy == '0) && (dz == '0))
    else $error("zero distance without forward direction");

  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(dx) <= $signed(sdi_pkg::DIR_ONE))
               && ($signed(dx) >= -$signed(sdi_pkg::DIR_ONE)))
    else $error("direction x beyond unit");

endmodule

bind star_distance_illumination sdi_checker u_sdi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_port.ready),
  .out_valid (out_port.valid),
  .out_ready (out_port.ready),
  .star_dist (out_port.star_distance),
  .dx        (out_port.dir_x),
  .dy        (out_port.dir_y),
  .dz        (out_port.dir_z)
);
`default_nettype wire

// File: dv/sdi_check.sv
`default_nettype none
// Watches the three channels, computes expected lighting words and compares.
module sdi_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [23:0]                  planet_x,
  input  logic [23:0]                  planet_y,
  input  logic [23:0]                  planet_z,
  input  logic [23:0]                  star_x,
  input  logic [23:0]                  star_y,
  input  logic [23:0]                  star_z,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [sdi_pkg::DIST_W-1:0]   star_distance,
  input  logic [sdi_pkg::DIR_W-1:0]    dir_x,
  input  logic [sdi_pkg::DIR_W-1:0]    dir_y,
  input  logic [sdi_pkg::DIR_W-1:0]    dir_z,
  input  logic [sdi_pkg::ILL_W-1:0]    illumination,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [sdi_pkg::IDX_W-1:0]    cfg_index,
  input  logic [sdi_pkg::CFG_DW-1:0]   cfg_data,
  output int                           errors,
  output int                           pending
);

  typedef struct packed {
    logic [sdi_pkg::DIST_W-1:0] distance;
    logic [sdi_pkg::DIR_W-1:0]  dx;
    logic [sdi_pkg::DIR_W-1:0]  dy;
    logic [sdi_pkg::DIR_W-1:0]  dz;
    logic [sdi_pkg::ILL_W-1:0]  illum;
  } light_t;

  sdi_pkg::cfg_t regs;
  light_t        light_q[$];

  assign pending = light_q.size();

  function automatic logic [15:0] clamp_illum(logic [31:0] v);
    if (v < regs.min_illumination) return regs.min_illumination;
    if (v < regs.max_illumination) return v[15:0];
    return regs.max_illumination;
  endfunction

  function automatic light_t predict_light(logic [23:0] p[3], logic [23:0] s[3]);
    light_t r;
    logic [63:0] m[3];
    logic        neg[3];
    logic [127:0] sq, xs, n, prod, dq, tt, q;
    logic [63:0] t, c, r64;
    logic signed [63:0] d;
    r = '0;
    r.dx = sdi_pkg::DIR_ONE;
    if (!regs.star_present) begin
      r.illum = clamp_illum(32'd4096);
      return r;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      d = $signed(s[i]) - $signed(p[i]);
      neg[i] = d < 0;
      m[i] = neg[i] ? -d : d;
      sq += 128'(m[i]) * m[i];
    end
    if (sq == 0) begin
      r.illum = regs.max_illumination;
      return r;
    end
    xs = sq << 28;
    dq = 0;
    for (int b = 47; b >= 0; b--) begin
      tt = dq | (128'd1 << b);
      if (tt * tt <= xs) dq = tt;
    end
    tt = (dq + 8192) >> 14;
    r.distance = tt > 128'h1FFFFFF ? 25'h1FFFFFF : tt[24:0];
    for (int i = 0; i < 3; i++) begin
      q = ((128'(m[i]) << 28) + (dq >> 1)) / dq;
      if (q > 16384) q = 16384;
      tt = neg[i] ? -q : q;
      if (i == 0) r.dx = tt[15:0];
      else if (i == 1) r.dy = tt[15:0];
      else r.dz = tt[15:0];
    end
    r64 = regs.reference_distance == 0 ? 1 : regs.reference_distance;
    n = (128'(r64) * r64) << 12;
    t = 0;
    for (int b = 15; b >= 0; b--) begin
      c = t | (64'd1 << b);
      prod = sq * c;
      if (prod <= n) t = c;
    end
    prod = sq * (2 * t + 1);
    if (t < 65535 && prod <= (n << 1)) t++;
    c = regs.compensation > sdi_pkg::COMP_FULL ? 4096 : regs.compensation;
    t = (t * (4096 - c) + 4096 * c + 2048) >> 12;
    r.illum = clamp_illum(t > 65535 ? 32'd65535 : t[31:0]);
    return r;
  endfunction

  always @(posedge clk) begin
    light_t got, exp_l;
    if (!rst_n) begin
      errors = 0;
      regs.star_present       <= 1'b0;
      regs.reference_distance <= 24'd1;
      regs.compensation       <= '0;
      regs.min_illumination   <= '0;
      regs.max_illumination   <= 16'hFFFF;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sdi_pkg::REG_STAR_PRESENT: regs.star_present <= cfg_data[0];
          sdi_pkg::REG_REF_DIST:
            regs.reference_distance <= cfg_data[sdi_pkg::REF_W-1:0];
          sdi_pkg::REG_COMPENSATION:
            regs.compensation <= cfg_data[sdi_pkg::COMP_W-1:0];
          sdi_pkg::REG_MIN_ILLUM:
            regs.min_illumination <= cfg_data[sdi_pkg::ILL_W-1:0];
          sdi_pkg::REG_MAX_ILLUM:
            regs.max_illumination <= cfg_data[sdi_pkg::ILL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        light_q.push_back(predict_light('{planet_x, planet_y, planet_z},
                                        '{star_x, star_y, star_z}));
      if (out_valid && out_ready) begin
        got = '{star_distance, dir_x, dir_y, dir_z, illumination};
        if (light_q.size() == 0) begin
          errors++;
          $display("%0t unexpected word: got %h", $time, got);
        end else begin
          exp_l = light_q.pop_front();
          if (got !== exp_l) begin
            errors++;
            $display("%0t mismatch: exp dist %0d dir %h %h %h ill %h", $time,
                     exp_l.distance, exp_l.dx, exp_l.dy, exp_l.dz, exp_l.illum);
            $display("%0t           got dist %0d dir %h %h %h ill %h", $time,
                     got.distance, got.dx, got.dy, got.dz, got.illum);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: dv/star_distance_illumination_test.sv
`default_nettype none
module star_distance_illumination_test;

  localparam int LATENCY = 81;
  localparam int LIMIT   = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle = 0;
  int   errors, pending;
  int   phase = 0;   // random phase in progress; phase 3 gets the long receiver hold

  sdi_in_if  #(.W(24)) in_port ();
  sdi_out_if           out_port ();
  sdi_cfg_if           cfg_port ();

  star_distance_illumination u_top (
    .clk(clk), .rst_n(rst_n),
    .in_port(in_port), .out_port(out_port), .cfg_port(cfg_port)
  );

  sdi_check u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_port.valid), .in_ready(in_port.ready),
    .planet_x(in_port.planet_x), .planet_y(in_port.planet_y), .planet_z(in_port.planet_z),
    .star_x(in_port.star_x), .star_y(in_port.star_y), .star_z(in_port.star_z),
    .out_valid(out_port.valid), .out_ready(out_port.ready),
    .star_distance(out_port.star_distance),
    .dir_x(out_port.dir_x), .dir_y(out_port.dir_y), .dir_z(out_port.dir_z),
    .illumination(out_port.illumination),
    .cfg_valid(cfg_port.valid), .cfg_ready(cfg_port.ready),
    .cfg_index(cfg_port.index), .cfg_data(cfg_port.data),
    .errors(errors), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("[star_distance_illumination] ERROR");
      $finish;
    end
  end

  // gap length: mostly zero or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random back-pressure, plus one long hold during phase 3
  initial begin
    int g;
    bit held;
    held = 1'b0;
    out_port.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (phase == 3 && !held) begin
        held = 1'b1;
        out_port.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      g = gap_len();
      if (g > 0 && $urandom_range(0, 3) == 0) begin
        out_port.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_port.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic write_reg(logic [sdi_pkg::IDX_W-1:0] idx, logic [sdi_pkg::CFG_DW-1:0] val);
    cfg_port.valid <= 1'b1;
    cfg_port.index <= idx;
    cfg_port.data  <= val;
    @(posedge clk iff cfg_port.ready);
    cfg_port.valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering, wait until all words are back, then let the pipe drain
  task automatic drain();
    in_port.valid <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic send_pos(logic [23:0] px, logic [23:0] py, logic [23:0] pz,
                          logic [23:0] sx, logic [23:0] sy, logic [23:0] sz,
                          bit gaps);
    int g;
    in_port.valid    <= 1'b1;
    in_port.planet_x <= px;
    in_port.planet_y <= py;
    in_port.planet_z <= pz;
    in_port.star_x   <= sx;
    in_port.star_y   <= sy;
    in_port.star_z   <= sz;
    @(posedge clk iff in_port.ready);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_port.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [23:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 24'h800000 | 24'($urandom_range(0, 15));
      1: return 24'h7FFFF0 | 24'($urandom_range(0, 15));
      2: return 24'($signed($urandom_range(0, 64)) - 32);
      3: return 24'($signed($urandom_range(0, 8000)) - 4000);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    logic [23:0] px, py, pz;
    for (int i = 0; i < count; i++) begin
      px = rnd_coord(); py = rnd_coord(); pz = rnd_coord();
      if ($urandom_range(0, 19) == 0)
        send_pos(px, py, pz, px, py, pz, 1);  // coincident bodies
      else
        send_pos(px, py, pz, rnd_coord(), rnd_coord(), rnd_coord(), 1);
    end
  endtask

  // random settings for one phase; extremes show up often
  task automatic random_settings();
    logic [sdi_pkg::CFG_DW-1:0] ref_d, comp, mn, mx;
    ref_d = $urandom_range(0, 2) == 0 ? 24'($urandom_range(0, 2))
          : $urandom_range(0, 1) ? 24'hFFFFFF : 24'($urandom_range(1, 20000));
    comp  = $urandom_range(0, 2) == 0 ? 24'h1FFF : 24'($urandom_range(0, 4096));
    mn    = $urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(0, 65535));
    mx    = $urandom_range(0, 1) ? 24'hFFFF : 24'($urandom_range(0, 65535));
    write_reg(sdi_pkg::REG_STAR_PRESENT, 24'($urandom_range(0, 7) != 0));
    write_reg(sdi_pkg::REG_REF_DIST, ref_d);
    write_reg(sdi_pkg::REG_COMPENSATION, comp);
    write_reg(sdi_pkg::REG_MIN_ILLUM, mn);
    write_reg(sdi_pkg::REG_MAX_ILLUM, mx);
  endtask

  initial begin
    in_port.valid    <= 1'b0;
    in_port.planet_x <= '0; in_port.planet_y <= '0; in_port.planet_z <= '0;
    in_port.star_x   <= '0; in_port.star_y   <= '0; in_port.star_z   <= '0;
    cfg_port.valid   <= 1'b0;
    cfg_port.index   <= sdi_pkg::REG_STAR_PRESENT;
    cfg_port.data    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no star: default lighting at reset settings
    send_pos(24'h000000, 24'h000000, 24'h000000, 24'h000100, 24'h0, 24'h0, 0);
    drain();
    write_reg(sdi_pkg::REG_STAR_PRESENT, 24'd1);
    write_reg(3'd7, 24'hFFFFFF);  // unused index, must be ignored
    // directed: coincident, axes, extremes both ways
    send_pos(24'h000005, 24'hFFFFFB, 24'h000007, 24'h000005, 24'hFFFFFB, 24'h000007, 0);
    send_pos(24'h0, 24'h0, 24'h0, 24'h000001, 24'h0, 24'h0, 0);
    send_pos(24'h0, 24'h0, 24'h0, 24'h0, 24'hFFFFFF, 24'h0, 0);
    send_pos(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h000003, 0);
    send_pos(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0);
    send_pos(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000, 0);
    send_pos(24'h800000, 24'h7FFFFF, 24'h0, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 0);
    send_pos(24'h0, 24'h0, 24'h0, 24'h000003, 24'h000004, 24'h0, 0);
    send_pos(24'hFFFFFF, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 0);
    drain();
    // min above max, zero reference, full and over-range compensation
    write_reg(sdi_pkg::REG_REF_DIST, 24'd0);
    write_reg(sdi_pkg::REG_COMPENSATION, 24'h1FFF);
    write_reg(sdi_pkg::REG_MIN_ILLUM, 24'h9000);
    write_reg(sdi_pkg::REG_MAX_ILLUM, 24'h1000);
    send_pos(24'h0, 24'h0, 24'h0, 24'h000002, 24'h0, 24'h0, 0);
    send_pos(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 0);
    drain();
    write_reg(sdi_pkg::REG_REF_DIST, 24'hFFFFFF);
    write_reg(sdi_pkg::REG_COMPENSATION, 24'd2048);
    write_reg(sdi_pkg::REG_MIN_ILLUM, 24'd0);
    write_reg(sdi_pkg::REG_MAX_ILLUM, 24'hFFFF);
    send_pos(24'h0, 24'h0, 24'h0, 24'h000001, 24'h000001, 24'h000001, 0);
    send_pos(24'h0, 24'h0, 24'h0, 24'h7FFFFF, 24'h0, 24'h0, 0);
    drain();

    // random phases; one phase runs under a long receiver hold to fill the pipe
    for (int ph = 0; ph < 12; ph++) begin
      random_settings();
      phase = ph;
      send_random(150);
      drain();
    end

    if (errors == 0) begin
      $display("[star_distance_illumination] OK");
    end else begin
      $display("[star_distance_illumination] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
hdl/sdi_pkg.sv
hdl/sdi_in_if.sv
hdl/sdi_out_if.sv
hdl/sdi_cfg_if.sv
hdl/sdi_front.sv
hdl/sdi_recip.sv
hdl/sdi_sqrt.sv
hdl/sdi_dirdiv.sv
hdl/star_distance_illumination.sv
hdl/sdi_checker.sv
dv/sdi_check.sv
dv/star_distance_illumination_test.sv
